/* sv/pseudo_face_incidence_filter_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the pseudo face incidence filter
// ----------------------------------------------------------------------------
`ifndef PSEUDO_FACE_INCIDENCE_FILTER_DEFINES_SVH
`define PSEUDO_FACE_INCIDENCE_FILTER_DEFINES_SVH

// same-cycle (overlapping) implication under the checker clock
`define PFIF_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("pfif check failed");

// next-cycle implication
`define PFIF_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("pfif check failed");

// check that is also active in reset
`define PFIF_ASSERT_RST(lbl, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("pfif reset check failed");

`endif

/* sv/pfif_pkg.sv */
// ----------------------------------------------------------------------------
// pfif_pkg
// Shared widths and stage payload types of the incidence filter.
// ----------------------------------------------------------------------------
package pfif_pkg;
  localparam int COORD_WIDTH = 32;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int HB_W        = $clog2(DIFF_W);
  localparam int SC_W        = 30;            // scaled magnitude
  localparam int SQ_IN_W     = 62;            // sum of squares
  localparam int ROOT_W      = 31;
  localparam int REM_W       = 34;
  localparam int AD_W        = 48;            // |dot| and division numerator
  localparam int Q_W         = 18;
  localparam int DV_W        = 32;
  localparam int DREM_W      = 33;
  localparam int CFG_A_W     = 2;

  typedef enum logic [CFG_A_W-1:0] {
    REG_VIEW_X = 2'd0,
    REG_VIEW_Y = 2'd1,
    REG_VIEW_Z = 2'd2,
    REG_THRESH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic            valid;
    logic            last;
    logic            zero;
    logic            neg;
    logic [AD_W-1:0] ad;
  } sq_side_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic zero;
    logic neg;
  } dv_side_t;
endpackage

/* sv/pfif_front.sv */
// ----------------------------------------------------------------------------
// pfif_front
// View ray, common scaling, squares and dot product, four stages.
// ----------------------------------------------------------------------------
module pfif_front import pfif_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic                          in_last,
  input  logic signed [COORD_WIDTH-1:0] cx, cy, cz,
  input  logic signed [15:0]            nx, ny, nz,
  input  logic signed [COORD_WIDTH-1:0] vx, vy, vz,
  output sq_side_t                      side,
  output logic [SQ_IN_W-1:0]            ssum
);
  // stage A
  logic [DIFF_W-1:0] ma_r [3];
  logic [2:0]        sa_r;
  logic [DIFF_W-1:0] mx_r;
  logic signed [15:0] na_r [3];
  logic va_r, la_r;
  // stage B
  logic [SC_W-1:0]   mb_r [3];
  logic [2:0]        sb_r;
  logic              zb_r;
  logic signed [15:0] nb_r [3];
  logic vb_r, lb_r;
  // stage C
  logic [2*SC_W-1:0]  sqc_r [3];
  logic signed [46:0] dpc_r [3];
  logic zc_r, vc_r, lc_r;
  // stage D
  logic [SQ_IN_W-1:0] ssum_r;
  sq_side_t           side_r;

  logic signed [DIFF_W-1:0] d [3];
  logic [DIFF_W-1:0]        m [3];
  logic [DIFF_W-1:0]        mx;
  logic [HB_W-1:0]          hb;
  logic [SC_W-1:0]          sc [3];
  logic signed [SC_W:0]     ss [3];
  logic signed [48:0]       dsum;
  logic [SQ_IN_W-1:0]       qsum;

  always_comb begin
    d[0] = DIFF_W'(cx) - DIFF_W'(vx);
    d[1] = DIFF_W'(cy) - DIFF_W'(vy);
    d[2] = DIFF_W'(cz) - DIFF_W'(vz);
    for (int i = 0; i < 3; i++) m[i] = d[i][DIFF_W-1] ? DIFF_W'(-d[i]) : DIFF_W'(d[i]);
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
  end

  always_comb begin
    hb = '0;
    for (int b = 0; b < DIFF_W; b++) if (mx_r[b]) hb = HB_W'(b);
    for (int i = 0; i < 3; i++) begin
      if (hb >= HB_W'(29)) sc[i] = SC_W'(ma_r[i] >> (hb - HB_W'(29)));
      else                 sc[i] = SC_W'(ma_r[i] << (HB_W'(29) - hb));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++)
      ss[i] = sb_r[i] ? -$signed({1'b0, mb_r[i]}) : $signed({1'b0, mb_r[i]});
    dsum = 49'(dpc_r[0]) + 49'(dpc_r[1]) + 49'(dpc_r[2]);
    qsum = SQ_IN_W'(sqc_r[0]) + SQ_IN_W'(sqc_r[1]) + SQ_IN_W'(sqc_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0; vb_r <= 1'b0; vc_r <= 1'b0; side_r.valid <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid; vb_r <= va_r; vc_r <= vb_r; side_r.valid <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ma_r[i]  <= m[i];
        sa_r[i]  <= d[i][DIFF_W-1];
        mb_r[i]  <= sc[i];
        sb_r[i]  <= sa_r[i];
        nb_r[i]  <= na_r[i];
        sqc_r[i] <= mb_r[i] * mb_r[i];
        dpc_r[i] <= 47'(ss[i]) * 47'(nb_r[i]);
      end
      na_r[0] <= nx; na_r[1] <= ny; na_r[2] <= nz;
      mx_r <= mx;
      la_r <= in_last;
      zb_r <= (mx_r == '0);
      lb_r <= la_r;
      zc_r <= zb_r;
      lc_r <= lb_r;
      ssum_r      <= qsum;
      side_r.last <= lc_r;
      side_r.zero <= zc_r;
      side_r.neg  <= dsum[48];
      side_r.ad   <= dsum[48] ? AD_W'(-dsum) : AD_W'(dsum);
    end
  end

  assign side = side_r;
  assign ssum = ssum_r;
endmodule

/* sv/pfif_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// pfif_sqrt_cell
// One result bit of the integer square root; two radicand bits per cell.
// ----------------------------------------------------------------------------
module pfif_sqrt_cell import pfif_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  sq_side_t           side_i,
  input  logic [SQ_IN_W-1:0] s_i,
  input  logic [REM_W-1:0]   rem_i,
  input  logic [ROOT_W-1:0]  root_i,
  output sq_side_t           side_o,
  output logic [SQ_IN_W-1:0] s_o,
  output logic [REM_W-1:0]   rem_o,
  output logic [ROOT_W-1:0]  root_o
);
  sq_side_t           side_r;
  logic [SQ_IN_W-1:0] s_r;
  logic [REM_W-1:0]   rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [REM_W-1:0]   rem_nxt, acc, trial;
  logic [ROOT_W-1:0]  root_nxt;

  always_comb begin
    acc   = {rem_i[REM_W-3:0], s_i[SQ_IN_W-1 -: 2]};
    trial = REM_W'({root_i, 2'b01});
    if (acc >= trial) begin
      rem_nxt  = acc - trial;
      root_nxt = {root_i[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = acc;
      root_nxt = {root_i[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) side_r.valid <= 1'b0;
    else if (adv) side_r.valid <= side_i.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r.last <= side_i.last;
      side_r.zero <= side_i.zero;
      side_r.neg  <= side_i.neg;
      side_r.ad   <= side_i.ad;
      s_r         <= {s_i[SQ_IN_W-3:0], 2'b00};
      rem_r       <= rem_nxt;
      root_r      <= root_nxt;
    end
  end

  assign side_o = side_r;
  assign s_o    = s_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
endmodule

/* sv/pfif_div_cell.sv */
// ----------------------------------------------------------------------------
// pfif_div_cell
// One quotient bit of the restoring divider.
// ----------------------------------------------------------------------------
module pfif_div_cell import pfif_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  dv_side_t          side_i,
  input  logic [AD_W-1:0]   num_i,
  input  logic [DV_W-1:0]   dv_i,
  input  logic [DREM_W-1:0] rem_i,
  input  logic [Q_W-1:0]    q_i,
  output dv_side_t          side_o,
  output logic [AD_W-1:0]   num_o,
  output logic [DV_W-1:0]   dv_o,
  output logic [DREM_W-1:0] rem_o,
  output logic [Q_W-1:0]    q_o
);
  dv_side_t          side_r;
  logic [AD_W-1:0]   num_r;
  logic [DV_W-1:0]   dv_r;
  logic [DREM_W-1:0] rem_r;
  logic [Q_W-1:0]    q_r;
  logic [DREM_W:0]   acc;
  logic [DREM_W-1:0] rem_nxt;
  logic              qb;

  always_comb begin
    acc = {rem_i, num_i[AD_W-1]};
    qb  = (acc >= (DREM_W+1)'(dv_i));
    rem_nxt = qb ? DREM_W'(acc - (DREM_W+1)'(dv_i)) : DREM_W'(acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) side_r.valid <= 1'b0;
    else if (adv) side_r.valid <= side_i.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r.last <= side_i.last;
      side_r.zero <= side_i.zero;
      side_r.neg  <= side_i.neg;
      num_r       <= {num_i[AD_W-2:0], 1'b0};
      dv_r        <= dv_i;
      rem_r       <= rem_nxt;
      q_r         <= {q_i[Q_W-2:0], qb};
    end
  end

  assign side_o = side_r;
  assign num_o  = num_r;
  assign dv_o   = dv_r;
  assign rem_o  = rem_r;
  assign q_o    = q_r;
endmodule

/* sv/pseudo_face_incidence_filter.sv */
// ----------------------------------------------------------------------------
// pseudo_face_incidence_filter
// Cosine of view ray and normal; keeps faces at/above threshold or at the view point.
//
//   channel | dir | payload
//   in_     | in  | face center, normal, last_face (tlast)
//   out_    | out | face_weight (tdata), keep_face (tuser), last_out (tlast)
//   cfg_    | in  | view point and threshold writes
//
// One request per cycle unless out_ stalls, as set by the lockstep chain of
// front stages, 31 sqrt cells, prep register, 18 divider cells, output register.
// Synchronous active-low reset clears valids and config registers.
// A stall on out_ freezes the whole chain; in_tready = !out_tvalid | out_tready.
// ----------------------------------------------------------------------------
module pseudo_face_incidence_filter import pfif_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // center_x, center_y, center_z, normal_x, normal_y, normal_z
  input  logic [3*COORD_WIDTH+47:0] in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // face_weight
  output logic [15:0]           out_tdata,
  // keep_face
  output logic                  out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [CFG_A_W-1:0]    cfg_addr,
  input  logic [31:0]           cfg_wdata
);
  localparam int NSQ = ROOT_W;
  localparam int CW  = COORD_WIDTH;

  logic signed [CW-1:0] view_x_r, view_y_r, view_z_r;
  logic [15:0]          thresh_r;
  logic                 adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_x_r <= '0; view_y_r <= '0; view_z_r <= '0; thresh_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_VIEW_X: view_x_r <= CW'(cfg_wdata);
        REG_VIEW_Y: view_y_r <= CW'(cfg_wdata);
        REG_VIEW_Z: view_z_r <= CW'(cfg_wdata);
        REG_THRESH: thresh_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  sq_side_t           sq_side [NSQ+1];
  logic [SQ_IN_W-1:0] sq_s    [NSQ+1];
  logic [REM_W-1:0]   sq_rem  [NSQ+1];
  logic [ROOT_W-1:0]  sq_root [NSQ+1];

  pfif_front u_front (
    .clk, .rst_n, .adv,
    .in_valid (in_tvalid && in_tready),
    .in_last  (in_tlast),
    .cx (in_tdata[CW-1:0]), .cy (in_tdata[2*CW-1:CW]), .cz (in_tdata[3*CW-1:2*CW]),
    .nx (in_tdata[3*CW+15:3*CW]), .ny (in_tdata[3*CW+31:3*CW+16]),
    .nz (in_tdata[3*CW+47:3*CW+32]),
    .vx (view_x_r), .vy (view_y_r), .vz (view_z_r),
    .side (sq_side[0]), .ssum (sq_s[0])
  );
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar g = 0; g < NSQ; g++) begin : g_sq
    pfif_sqrt_cell u_cell (
      .clk, .rst_n, .adv,
      .side_i (sq_side[g]), .s_i (sq_s[g]), .rem_i (sq_rem[g]), .root_i (sq_root[g]),
      .side_o (sq_side[g+1]), .s_o (sq_s[g+1]), .rem_o (sq_rem[g+1]),
      .root_o (sq_root[g+1])
    );
  end

  dv_side_t          dv_side [Q_W+1];
  logic [AD_W-1:0]   dv_num  [Q_W+1];
  logic [DV_W-1:0]   dv_dv   [Q_W+1];
  logic [DREM_W-1:0] dv_rem  [Q_W+1];
  logic [Q_W-1:0]    dv_q    [Q_W+1];
  dv_side_t          pr_side_r;
  logic [AD_W-1:0]   pr_num_r;
  logic [DV_W-1:0]   pr_dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) pr_side_r.valid <= 1'b0;
    else if (adv) pr_side_r.valid <= sq_side[NSQ].valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_side_r.last <= sq_side[NSQ].last;
      pr_side_r.zero <= sq_side[NSQ].zero;
      pr_side_r.neg  <= sq_side[NSQ].neg;
      pr_num_r <= {sq_side[NSQ].ad[AD_W-2:0], 1'b0} + AD_W'(sq_root[NSQ]);
      pr_dv_r  <= {sq_root[NSQ], 1'b0};
    end
  end

  // quotient fits in Q_W bits, so the upper numerator bits seed the remainder
  assign dv_side[0] = pr_side_r;
  assign dv_num[0]  = {pr_num_r[Q_W-1:0], {(AD_W-Q_W){1'b0}}};
  assign dv_dv[0]   = pr_dv_r;
  assign dv_rem[0]  = DREM_W'(pr_num_r[AD_W-1:Q_W]);
  assign dv_q[0]    = '0;

  for (genvar g = 0; g < Q_W; g++) begin : g_dv
    pfif_div_cell u_cell (
      .clk, .rst_n, .adv,
      .side_i (dv_side[g]), .num_i (dv_num[g]), .dv_i (dv_dv[g]),
      .rem_i (dv_rem[g]), .q_i (dv_q[g]),
      .side_o (dv_side[g+1]), .num_o (dv_num[g+1]), .dv_o (dv_dv[g+1]),
      .rem_o (dv_rem[g+1]), .q_o (dv_q[g+1])
    );
  end

  logic [Q_W-1:0] qf;
  logic [15:0]    w;
  logic [16:0]    aw;
  logic           keep;
  logic           ov_r;
  logic [15:0]    w_r;
  logic           keep_r, last_r;

  always_comb begin
    qf = dv_q[Q_W];
    if (dv_side[Q_W].neg) begin
      if (qf > Q_W'(32768)) begin
        w = 16'h8000; aw = 17'd32768;
      end else begin
        w = 16'(-qf); aw = 17'(qf);
      end
    end else begin
      if (qf > Q_W'(32767)) begin
        w = 16'h7fff; aw = 17'd32767;
      end else begin
        w = 16'(qf); aw = 17'(qf);
      end
    end
    if (dv_side[Q_W].zero) begin
      w = '0; keep = 1'b1;
    end else begin
      keep = (aw >= {1'b0, thresh_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= dv_side[Q_W].valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_r    <= w;
      keep_r <= keep;
      last_r <= dv_side[Q_W].last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = w_r;
  assign out_tuser  = keep_r;
  assign out_tlast  = last_r;
endmodule

/* sv/pfif_checker.sv */
// ----------------------------------------------------------------------------
// pfif_checker
// Port-level checks of the incidence filter.
// ----------------------------------------------------------------------------
`include "pseudo_face_incidence_filter_defines.svh"

module pfif_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);
  `PFIF_ASSERT_RST(a_rst_clear, !rst_n, !out_tvalid)
  `PFIF_ASSERT_IMP(a_ready_free, !out_tvalid || out_tready, in_tready)
  `PFIF_ASSERT_IMP(a_ready_stall, out_tvalid && !out_tready, !in_tready)
  `PFIF_ASSERT_NXT(a_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
endmodule

bind pseudo_face_incidence_filter pfif_checker u_pfif_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
  .out_tdata, .out_tuser, .out_tlast
);
